// ----- sv/ansi_sgr_attribute_decoder_macros.svh -----
// ---------------------------------------------------------------------------
// ANSI SGR attribute decoder assertion macros
// Clocked assertion wrappers for the decoder's concurrent checks.
// ---------------------------------------------------------------------------
`ifndef ANSI_SGR_ATTRIBUTE_DECODER_MACROS_SVH
`define ANSI_SGR_ATTRIBUTE_DECODER_MACROS_SVH

// check on clk_i, masked while rst_ni is low
`define ASAD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// check on clk_i, also active while rst_ni is low
`define ASAD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- sv/asad_pkg.sv -----
// ---------------------------------------------------------------------------
// ANSI SGR attribute decoder package
// Payload structs, SGR codes, flag bit positions and the color map.
// ---------------------------------------------------------------------------
package asad_pkg;

  typedef struct packed {
    logic [7:0] sgr_param;
    logic       last;
  } asad_in_t;

  typedef struct packed {
    logic [5:0] effective_fg;
    logic [5:0] effective_bg;
    logic [8:0] attr_flags;
  } asad_out_t;

  // configuration register indexes
  localparam logic CFG_DEFAULT_FG = 1'b0;
  localparam logic CFG_DEFAULT_BG = 1'b1;

  // color codes
  localparam logic [5:0] COL_WHITE       = 6'd15;
  localparam logic [5:0] COL_DEFAULT     = 6'd16;
  localparam logic [5:0] COL_TRANSPARENT = 6'd32;
  localparam logic [5:0] COL_BRIGHT_OFS  = 6'd8;
  localparam logic [5:0] FG_RESET        = 6'd7;
  localparam logic [5:0] BG_RESET        = 6'd0;

  // flag bit positions
  localparam int unsigned FLAG_BOLD      = 0;
  localparam int unsigned FLAG_BLINK     = 1;
  localparam int unsigned FLAG_ITALICS   = 2;
  localparam int unsigned FLAG_NEGATIVE  = 3;
  localparam int unsigned FLAG_CONCEALED = 4;
  localparam int unsigned FLAG_UNDERLINE = 5;
  localparam int unsigned FLAG_FAINT     = 6;
  localparam int unsigned FLAG_STRIKE    = 7;
  localparam int unsigned FLAG_PROP      = 8;

  // color ranges
  localparam logic [7:0] SGR_FG_LO        = 8'd30;
  localparam logic [7:0] SGR_FG_HI        = 8'd37;
  localparam logic [7:0] SGR_BG_LO        = 8'd40;
  localparam logic [7:0] SGR_BG_HI        = 8'd47;
  localparam logic [7:0] SGR_FG_BRIGHT_LO = 8'd90;
  localparam logic [7:0] SGR_FG_BRIGHT_HI = 8'd97;
  localparam logic [7:0] SGR_BG_BRIGHT_LO = 8'd100;
  localparam logic [7:0] SGR_BG_BRIGHT_HI = 8'd107;

  // single codes
  localparam logic [7:0] SGR_RESET           = 8'd0;
  localparam logic [7:0] SGR_BOLD            = 8'd1;
  localparam logic [7:0] SGR_FAINT           = 8'd2;
  localparam logic [7:0] SGR_ITALICS         = 8'd3;
  localparam logic [7:0] SGR_UNDERLINE       = 8'd4;
  localparam logic [7:0] SGR_BLINK_SLOW      = 8'd5;
  localparam logic [7:0] SGR_BLINK_FAST      = 8'd6;
  localparam logic [7:0] SGR_NEGATIVE        = 8'd7;
  localparam logic [7:0] SGR_CONCEAL         = 8'd8;
  localparam logic [7:0] SGR_STRIKE          = 8'd9;
  localparam logic [7:0] SGR_DBL_UNDERLINE   = 8'd21;
  localparam logic [7:0] SGR_NORMAL_INTENS   = 8'd22;
  localparam logic [7:0] SGR_NO_ITALICS      = 8'd23;
  localparam logic [7:0] SGR_NO_UNDERLINE    = 8'd24;
  localparam logic [7:0] SGR_NO_BLINK        = 8'd25;
  localparam logic [7:0] SGR_PROPORTIONAL    = 8'd26;
  localparam logic [7:0] SGR_NO_NEGATIVE     = 8'd27;
  localparam logic [7:0] SGR_NO_CONCEAL      = 8'd28;
  localparam logic [7:0] SGR_NO_STRIKE       = 8'd29;
  localparam logic [7:0] SGR_FG_DEFAULT      = 8'd39;
  localparam logic [7:0] SGR_BG_DEFAULT      = 8'd49;
  localparam logic [7:0] SGR_NO_PROPORTIONAL = 8'd50;

  // ANSI color order to CGA palette order
  function automatic logic [5:0] ansi_to_cga(input logic [2:0] idx);
    logic [5:0] col;
    case (idx)
      3'd0:    col = 6'd0;
      3'd1:    col = 6'd4;
      3'd2:    col = 6'd2;
      3'd3:    col = 6'd6;
      3'd4:    col = 6'd1;
      3'd5:    col = 6'd5;
      3'd6:    col = 6'd3;
      3'd7:    col = 6'd7;
      default: col = 6'd0;
    endcase
    return col;
  endfunction

endpackage

// ----- sv/ansi_sgr_attribute_decoder.sv -----
// ---------------------------------------------------------------------------
// ANSI SGR attribute decoder
// Applies SGR parameters to the rendition state and reports drawing colors.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_data_i) carries one SGR
//   parameter per word plus a last marker; an empty sequence arrives as a
//   single 0 with last set.
//   Every accepted word updates the current colors and flags in that cycle.
//   A word with last set also loads the output register, so its result word
//   appears on out_valid_o / out_data_o in the cycle after acceptance.
//   Throughput is one word per cycle: in_ready_o is high whenever the output
//   register is empty or is being drained in the same cycle.
//   If the receiver stalls with a result pending, in_ready_o drops and the
//   state holds until out_ready_i returns.
//   Reset restores colors 7 / 0, clears all flags and the output valid, and
//   sets the default color registers to 7 / 0.
//   cfg_we_i writes cfg_wdata_i into default_fg (index 0) or default_bg
//   (index 1); writes are registered with no handshake.
// ---------------------------------------------------------------------------
`include "ansi_sgr_attribute_decoder_macros.svh"

module ansi_sgr_attribute_decoder (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [5:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  asad_pkg::asad_in_t in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output asad_pkg::asad_out_t out_data_o
);
  import asad_pkg::*;

  logic [5:0] default_fg_q, default_bg_q;
  logic [5:0] cur_fg_q, cur_fg_d;
  logic [5:0] cur_bg_q, cur_bg_d;
  logic [8:0] flags_q, flags_d;
  logic       out_valid_q, out_valid_d;
  asad_out_t  out_data_q, res_d;
  logic       in_fire;
  logic [7:0] p;
  logic [7:0] ofs_fg, ofs_bg, ofs_fgb, ofs_bgb;
  logic [5:0] efg, ebg;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign p          = in_data_i.sgr_param;

  assign ofs_fg  = p - SGR_FG_LO;
  assign ofs_bg  = p - SGR_BG_LO;
  assign ofs_fgb = p - SGR_FG_BRIGHT_LO;
  assign ofs_bgb = p - SGR_BG_BRIGHT_LO;

  // parameter decode
  always_comb begin
    cur_fg_d = cur_fg_q;
    cur_bg_d = cur_bg_q;
    flags_d  = flags_q;
    if (p >= SGR_FG_LO && p <= SGR_FG_HI) begin
      cur_fg_d = ansi_to_cga(ofs_fg[2:0]);
    end else if (p >= SGR_BG_LO && p <= SGR_BG_HI) begin
      cur_bg_d = ansi_to_cga(ofs_bg[2:0]);
    end else if (p >= SGR_FG_BRIGHT_LO && p <= SGR_FG_BRIGHT_HI) begin
      cur_fg_d = ansi_to_cga(ofs_fgb[2:0]) + COL_BRIGHT_OFS;
    end else if (p >= SGR_BG_BRIGHT_LO && p <= SGR_BG_BRIGHT_HI) begin
      cur_bg_d = ansi_to_cga(ofs_bgb[2:0]) + COL_BRIGHT_OFS;
    end else begin
      case (p)
        SGR_RESET: begin
          cur_fg_d = default_fg_q;
          cur_bg_d = default_bg_q;
          flags_d  = '0;
        end
        SGR_BOLD:            flags_d[FLAG_BOLD]      = 1'b1;
        SGR_FAINT:           flags_d[FLAG_FAINT]     = 1'b1;
        SGR_ITALICS:         flags_d[FLAG_ITALICS]   = 1'b1;
        SGR_UNDERLINE,
        SGR_DBL_UNDERLINE:   flags_d[FLAG_UNDERLINE] = 1'b1;
        SGR_BLINK_SLOW,
        SGR_BLINK_FAST:      flags_d[FLAG_BLINK]     = 1'b1;
        SGR_NEGATIVE:        flags_d[FLAG_NEGATIVE]  = 1'b1;
        SGR_CONCEAL:         flags_d[FLAG_CONCEALED] = 1'b1;
        SGR_STRIKE:          flags_d[FLAG_STRIKE]    = 1'b1;
        SGR_NORMAL_INTENS: begin
          flags_d[FLAG_BOLD]  = 1'b0;
          flags_d[FLAG_FAINT] = 1'b0;
        end
        SGR_NO_ITALICS:      flags_d[FLAG_ITALICS]   = 1'b0;
        SGR_NO_UNDERLINE:    flags_d[FLAG_UNDERLINE] = 1'b0;
        SGR_NO_BLINK:        flags_d[FLAG_BLINK]     = 1'b0;
        SGR_PROPORTIONAL:    flags_d[FLAG_PROP]      = 1'b1;
        SGR_NO_NEGATIVE:     flags_d[FLAG_NEGATIVE]  = 1'b0;
        SGR_NO_CONCEAL:      flags_d[FLAG_CONCEALED] = 1'b0;
        SGR_NO_STRIKE:       flags_d[FLAG_STRIKE]    = 1'b0;
        SGR_FG_DEFAULT:      cur_fg_d = default_fg_q;
        SGR_BG_DEFAULT:      cur_bg_d = default_bg_q;
        SGR_NO_PROPORTIONAL: flags_d[FLAG_PROP]      = 1'b0;
        default: ;
      endcase
    end
  end

  // effective colors from the updated state
  always_comb begin
    if (flags_d[FLAG_CONCEALED]) begin
      efg = COL_TRANSPARENT;
      ebg = COL_TRANSPARENT;
    end else begin
      efg = flags_d[FLAG_NEGATIVE] ? cur_bg_d : cur_fg_d;
      ebg = flags_d[FLAG_NEGATIVE] ? cur_fg_d : cur_bg_d;
      if (flags_d[FLAG_BOLD]) begin
        if (efg < COL_BRIGHT_OFS) begin
          efg = efg + COL_BRIGHT_OFS;
        end else if (efg == COL_DEFAULT) begin
          efg = COL_WHITE;
        end
      end
    end
    res_d.effective_fg = efg;
    res_d.effective_bg = ebg;
    res_d.attr_flags   = flags_d;
  end

  assign out_valid_d = (in_fire && in_data_i.last) || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      default_fg_q <= FG_RESET;
      default_bg_q <= BG_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DEFAULT_FG: default_fg_q <= cfg_wdata_i;
        CFG_DEFAULT_BG: default_bg_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_fg_q    <= FG_RESET;
      cur_bg_q    <= BG_RESET;
      flags_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_fire) begin
        cur_fg_q <= cur_fg_d;
        cur_bg_q <= cur_bg_d;
        flags_q  <= flags_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && in_data_i.last) begin
      out_data_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `ASAD_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !out_valid_o, "result valid during reset")
  `ASAD_ASSERT(a_backpressure, out_valid_o && !out_ready_i |-> !in_ready_o, "input taken while output stalled")
  `ASAD_ASSERT(a_conceal, out_valid_o && out_data_o.attr_flags[FLAG_CONCEALED] |-> out_data_o.effective_fg == COL_TRANSPARENT && out_data_o.effective_bg == COL_TRANSPARENT, "concealed word not transparent")
  `ASAD_ASSERT(a_bold_bright, out_valid_o && out_data_o.attr_flags[FLAG_BOLD] && !out_data_o.attr_flags[FLAG_CONCEALED] |-> out_data_o.effective_fg >= COL_BRIGHT_OFS, "bold foreground left dark")

endmodule
